### hdl/brsm_pkg.sv
// ============================================================================
// brsm_pkg
// Shared codes for the radix-2 Booth multiplier: the recoding of a bit pair.
// ============================================================================
`default_nettype none

package brsm_pkg;

    // Booth pair {q0, q_minus1} examined in each round
    typedef enum logic [1:0] {
        BOOTH_HOLD_LO = 2'b00,
        BOOTH_ADD     = 2'b01,
        BOOTH_SUB     = 2'b10,
        BOOTH_HOLD_HI = 2'b11
    } t_booth_pair;

endpackage : brsm_pkg

`default_nettype wire

### hdl/booth_radix2_signed_multiplier_unit.sv
// ============================================================================
// booth_radix2_signed_multiplier_unit
// Pipelined radix-2 Booth multiplier: an operand stage, then one recoding round per register stage.
// ============================================================================
// Usage
//   Slave stream (s_axis) carries one operand pair per request: tdata holds
//   the multiplicand in bits [WIDTH-1:0] and the multiplier in bits
//   [2*WIDTH-1:WIDTH], zero padded to whole bytes. Master stream (m_axis)
//   returns the full 2*WIDTH-bit signed product in the low tdata bits.
//   A request is taken on an edge where tvalid and tready are both high.
//
// Pipeline and throughput
//   Stage 0 registers the operands, stages 1..WIDTH each run one Booth round
//   (one WIDTH-bit add or subtract plus the arithmetic shift). A product is
//   valid after stage 0 and each round stage in turn; one request is taken per cycle
//   while the receiver keeps taking products. The single adder in each round
//   stage sets the clock period, not the rate.
//
// Reset and stalls
//   i_rst_n (synchronous, active low) clears every stage valid bit; data
//   registers are not reset. When the receiver holds off tready, the output
//   stage holds its product and earlier stages keep filling bubbles, so input
//   is still taken until the pipe is full. Nothing is dropped or repeated.
//   The most negative multiplicand wraps on negation; the product is passed
//   through unchanged, with no flag.
// ============================================================================
`default_nettype none

module booth_radix2_signed_multiplier_unit #(
    parameter int WIDTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // s_axis tdata, low bit up: multiplicand[WIDTH], multiplier[WIDTH], zero pad
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [((2*WIDTH+7)/8)*8-1:0]       i_s_axis_tdata,
    // m_axis tdata, low bit up: product[2*WIDTH], zero pad
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic [((2*WIDTH+7)/8)*8-1:0]            o_m_axis_tdata
);

    import brsm_pkg::*;

    localparam int TDATA_W = ((2*WIDTH+7)/8)*8;
    localparam int LAST    = WIDTH;   // index of the final round stage

    // per-stage state: accumulator, multiplier/low product, q-1 bit, multiplicand
    logic             r_vld [0:LAST];
    logic [WIDTH-1:0] r_acc [0:LAST];
    logic [WIDTH-1:0] r_q   [0:LAST];
    logic             r_q1  [0:LAST];
    logic [WIDTH-1:0] r_m   [0:LAST];

    // stage s may load when it is empty or its content moves on this cycle
    logic             w_rdy [0:LAST];

    assign w_rdy[LAST] = !r_vld[LAST] || i_m_axis_tready;

    genvar s;
    generate
        for (s = 0; s < LAST; s++) begin : g_rdy
            assign w_rdy[s] = !r_vld[s] || w_rdy[s+1];
        end
    endgenerate

    assign o_s_axis_tready = w_rdy[0];

    // ---- stage 0: operand capture, A = 0, q-1 = 0 ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_vld[0] <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_s_axis_tvalid) begin
            r_m[0]   <= i_s_axis_tdata[WIDTH-1:0];
            r_q[0]   <= i_s_axis_tdata[2*WIDTH-1:WIDTH];
            r_acc[0] <= '0;
            r_q1[0]  <= 1'b0;
        end
    end

    // ---- stages 1..WIDTH: one Booth round each ----
    generate
        for (s = 1; s <= LAST; s++) begin : g_round
            t_booth_pair      w_pair;
            logic [WIDTH-1:0] w_sum;

            assign w_pair = t_booth_pair'({r_q[s-1][0], r_q1[s-1]});

            always_comb begin
                unique case (w_pair)
                    BOOTH_SUB: w_sum = r_acc[s-1] - r_m[s-1];
                    BOOTH_ADD: w_sum = r_acc[s-1] + r_m[s-1];
                    default:   w_sum = r_acc[s-1];
                endcase
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (w_rdy[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end

            // arithmetic shift right of {A,Q}; q-1 takes the old Q lsb
            always_ff @(posedge i_clk) begin
                if (w_rdy[s] && r_vld[s-1]) begin
                    r_acc[s] <= {w_sum[WIDTH-1], w_sum[WIDTH-1:1]};
                    r_q[s]   <= {w_sum[0], r_q[s-1][WIDTH-1:1]};
                    r_q1[s]  <= r_q[s-1][0];
                    r_m[s]   <= r_m[s-1];
                end
            end
        end
    endgenerate

    // ---- output: final stage drives the master stream directly ----
    assign o_m_axis_tvalid = r_vld[LAST];
    assign o_m_axis_tdata  = TDATA_W'({r_acc[LAST], r_q[LAST]});

endmodule : booth_radix2_signed_multiplier_unit

`default_nettype wire

### hdl/brsm_checker.sv
// ============================================================================
// brsm_checker
// Port-level checks for the Booth multiplier: handshake, flow and occupancy.
// ============================================================================
`default_nettype none

module brsm_checker #(
    parameter int WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    input  wire logic i_s_tready,
    input  wire logic i_m_tvalid,
    input  wire logic i_m_tready
);

    localparam int DEPTH = WIDTH + 1;
    localparam int CNT_W = $clog2(DEPTH + 2);

    logic [CNT_W-1:0] r_occ;
    logic [CNT_W-1:0] n_occ;
    logic             w_in_acc;
    logic             w_out_acc;

    assign w_in_acc  = i_s_tvalid && i_s_tready;
    assign w_out_acc = i_m_tvalid && i_m_tready;

    always_comb begin
        n_occ = r_occ + CNT_W'(w_in_acc) - CNT_W'(w_out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // a stalled product stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("product dropped while stalled");

    // an empty or draining output stage lets the whole pipe advance
    a_full_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_tvalid || i_m_tready |-> i_s_tready)
        else $error("input stalled while pipe can advance");

    // no product without a request in flight
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> r_occ != '0)
        else $error("product without request");

    // never more requests in flight than stages
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(DEPTH))
        else $error("more requests in flight than stages");

endmodule : brsm_checker

bind booth_radix2_signed_multiplier_unit brsm_checker #(
    .WIDTH(WIDTH)
) u_brsm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready)
);

`default_nettype wire
